@@ hdl/sha1sh_pkg.sv @@
// sha1sh_pkg: shared types, constants and control codes of the sha-1 stream hasher
// used by the controller, the datapath, the top level and the checker
package sha1sh_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned NumH   = 5;
  localparam int unsigned WinLen = 16;
  localparam int unsigned Rounds = 80;
  localparam int unsigned CountW = 61;

  localparam logic [NumH-1:0][WordW-1:0] InitChain = {
    32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
  };

  localparam logic [WordW-1:0] RoundK0 = 32'h5A827999;
  localparam logic [WordW-1:0] RoundK1 = 32'h6ED9EBA1;
  localparam logic [WordW-1:0] RoundK2 = 32'h8F1BBCDC;
  localparam logic [WordW-1:0] RoundK3 = 32'hCA62C1D6;
  localparam logic [7:0]       PadMark = 8'h80;

  typedef struct packed {
    logic       has_byte;
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic        digest_last;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_ROUND,
    ST_FINAL,
    ST_PAD,
    ST_CLEAR,
    ST_LEN,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    PH_DATA,
    PH_EXTRA,
    PH_LAST
  } phase_t;

  typedef struct packed {
    logic load_byte;
    logic pad_mark;
    logic clear_all;
    logic write_len;
    logic comp_init;
    logic round_step;
    logic chain_add;
    logic emit_next;
    logic msg_reset;
  } cmd_t;

  typedef struct packed {
    logic pos_full;
    logic pad_two;
    logic round_last;
    logic emit_last;
  } stat_t;

endpackage

@@ hdl/sha1sh_dpath.sv @@
// sha1sh_dpath: byte packing, schedule window, round logic, chaining words, byte count
// depends on sha1sh_pkg; driven by commands from sha1sh_ctrl
module sha1sh_dpath import sha1sh_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cmd_t      cmd,
  input  in_item_t  item,
  output stat_t     stat,
  output out_item_t digest
);

  logic [WordW-1:0]  chain [NumH];
  logic [WordW-1:0]  work  [NumH];
  logic [WordW-1:0]  win   [WinLen];
  logic [CountW-1:0] count;
  logic [6:0]        round_idx;
  logic [2:0]        emit_idx;

  logic [5:0]       pos;
  logic [3:0]       wsel;
  logic [7:0]       put_byte;
  logic [WordW-1:0] placed;
  logic [WordW-1:0] f_val;
  logic [WordW-1:0] k_val;
  logic [WordW-1:0] temp;
  logic [WordW-1:0] mix;
  logic [WordW-1:0] next_word;
  logic [63:0]      bit_len;

  assign pos      = count[5:0];
  assign wsel     = pos[5:2];
  assign put_byte = cmd.pad_mark ? PadMark : item.data_byte;
  // big-endian lane; lane 0 starts a fresh word
  assign placed   = ((pos[1:0] == 2'd0) ? '0 : win[wsel])
                  | ({24'd0, put_byte} << {~pos[1:0], 3'b000});
  assign bit_len  = {count, 3'b000};

  assign mix       = win[13] ^ win[8] ^ win[2] ^ win[0];
  assign next_word = {mix[30:0], mix[31]};

  always_comb begin
    priority if (round_idx < 7'd20) begin
      f_val = (work[1] & work[2]) | (~work[1] & work[3]);
      k_val = RoundK0;
    end else if (round_idx < 7'd40) begin
      f_val = work[1] ^ work[2] ^ work[3];
      k_val = RoundK1;
    end else if (round_idx < 7'd60) begin
      f_val = (work[1] & work[2]) | (work[1] & work[3]) | (work[2] & work[3]);
      k_val = RoundK2;
    end else begin
      f_val = work[1] ^ work[2] ^ work[3];
      k_val = RoundK3;
    end
  end

  assign temp = {work[0][26:0], work[0][31:27]} + f_val + work[4] + k_val + win[0];

  // window holds W[t..t+15] at round t and shifts by one word per round
  always_ff @(posedge clk) begin
    if (cmd.round_step) begin
      for (int j = 0; j < WinLen - 1; j++) begin
        win[j] <= win[j+1];
      end
      win[WinLen-1] <= next_word;
    end else if (cmd.load_byte || cmd.pad_mark) begin
      for (int j = 0; j < WinLen; j++) begin
        if (cmd.pad_mark && (4'(j) > wsel)) begin
          win[j] <= '0;
        end
      end
      win[wsel] <= placed;
    end else if (cmd.clear_all) begin
      for (int j = 0; j < WinLen; j++) begin
        win[j] <= '0;
      end
    end else if (cmd.write_len) begin
      win[14] <= bit_len[63:32];
      win[15] <= bit_len[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.comp_init) begin
      for (int j = 0; j < NumH; j++) begin
        work[j] <= chain[j];
      end
    end else if (cmd.round_step) begin
      work[4] <= work[3];
      work[3] <= work[2];
      work[2] <= {work[1][1:0], work[1][31:2]};
      work[1] <= work[0];
      work[0] <= temp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.msg_reset) begin
      for (int j = 0; j < NumH; j++) begin
        chain[j] <= InitChain[j];
      end
    end else if (cmd.chain_add) begin
      for (int j = 0; j < NumH; j++) begin
        chain[j] <= chain[j] + work[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.msg_reset) begin
      count <= '0;
    end else if (cmd.load_byte) begin
      count <= count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.comp_init) begin
      round_idx <= '0;
    end else if (cmd.round_step) begin
      round_idx <= round_idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.msg_reset) begin
      emit_idx <= '0;
    end else if (cmd.emit_next) begin
      emit_idx <= emit_idx + 1'b1;
    end
  end

  assign stat.pos_full   = &pos;
  assign stat.pad_two    = &pos[5:3];
  assign stat.round_last = (round_idx == 7'(Rounds - 1));
  assign stat.emit_last  = (emit_idx == 3'(NumH - 1));

  assign digest.digest_word = chain[emit_idx];
  assign digest.digest_last = stat.emit_last;

endmodule

@@ hdl/sha1sh_ctrl.sv @@
// sha1sh_ctrl: sequencer for byte intake, compression rounds, padding and digest output
// depends on sha1sh_pkg; commands sha1sh_dpath through cmd_t
module sha1sh_ctrl import sha1sh_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  byte_valid,
  input  logic  has_byte,
  input  logic  last_byte,
  input  logic  digest_ready,
  input  stat_t stat,
  output logic  byte_ready,
  output logic  digest_valid,
  output cmd_t  cmd
);

  state_t state, state_next;
  phase_t phase, phase_next;
  logic   pend_last, pend_last_next;
  logic   take;
  logic   give;

  assign take = byte_valid && (state == ST_IDLE);
  assign give = digest_ready && (state == ST_EMIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      phase     <= PH_DATA;
      pend_last <= 1'b0;
    end else begin
      state     <= state_next;
      phase     <= phase_next;
      pend_last <= pend_last_next;
    end
  end

  // next state
  always_comb begin
    state_next     = state;
    phase_next     = phase;
    pend_last_next = pend_last;
    unique case (state)
      ST_IDLE: begin
        if (take) begin
          if (has_byte && stat.pos_full) begin
            state_next     = ST_INIT;
            phase_next     = PH_DATA;
            pend_last_next = last_byte;
          end else if (last_byte) begin
            state_next = ST_PAD;
          end
        end
      end
      ST_INIT:  state_next = ST_ROUND;
      ST_ROUND: begin
        if (stat.round_last) begin
          state_next = ST_FINAL;
        end
      end
      ST_FINAL: begin
        unique case (phase)
          PH_DATA:  state_next = pend_last ? ST_PAD : ST_IDLE;
          PH_EXTRA: state_next = ST_CLEAR;
          PH_LAST:  state_next = ST_EMIT;
          default:  state_next = ST_IDLE;
        endcase
      end
      ST_PAD: begin
        if (stat.pad_two) begin
          state_next = ST_INIT;
          phase_next = PH_EXTRA;
        end else begin
          state_next = ST_LEN;
        end
      end
      ST_CLEAR: state_next = ST_LEN;
      ST_LEN: begin
        state_next = ST_INIT;
        phase_next = PH_LAST;
      end
      ST_EMIT: begin
        if (give && stat.emit_last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd          = '0;
    byte_ready   = 1'b0;
    digest_valid = 1'b0;
    unique case (state)
      ST_IDLE: begin
        byte_ready    = 1'b1;
        cmd.load_byte = take && has_byte;
      end
      ST_INIT:  cmd.comp_init  = 1'b1;
      ST_ROUND: cmd.round_step = 1'b1;
      ST_FINAL: cmd.chain_add  = 1'b1;
      ST_PAD:   cmd.pad_mark   = 1'b1;
      ST_CLEAR: cmd.clear_all  = 1'b1;
      ST_LEN:   cmd.write_len  = 1'b1;
      ST_EMIT: begin
        digest_valid  = 1'b1;
        cmd.emit_next = give;
        cmd.msg_reset = give && stat.emit_last;
      end
      default: ;
    endcase
  end

endmodule

@@ hdl/sha1_stream_hasher_core.sv @@
// a byte that does not fill a block leaves intake open; a byte that fills one
// holds intake through load, init, the compression rounds and the chaining add
// end of message: padding and final compression (with an extra block when the
// length no longer fits), then five digest transfers at up to one per cycle
// while digest_ready is high; intake takes one item at a time and stays closed
// while a block is compressed, during padding and during digest output
// reset (rst, synchronous): loads the initial chain, clears the byte count, goes idle
module sha1_stream_hasher_core import sha1sh_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      byte_valid,
  output logic      byte_ready,
  input  in_item_t  byte_data,
  output logic      digest_valid,
  input  logic      digest_ready,
  output out_item_t digest_data
);

  // command and status between the sequencer and the datapath
  cmd_t  cmd;
  stat_t stat;

  // sequencer: owns the handshakes and decides when to load, pad, compress and emit
  sha1sh_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .has_byte     (byte_data.has_byte),
    .last_byte    (byte_data.last_byte),
    .digest_ready (digest_ready),
    .stat         (stat),
    .byte_ready   (byte_ready),
    .digest_valid (digest_valid),
    .cmd          (cmd)
  );

  // datapath: schedule window, working words, chain words and byte count;
  // digest words come straight from the chain registers, so they hold while stalled
  sha1sh_dpath u_dpath (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .item   (byte_data),
    .stat   (stat),
    .digest (digest_data)
  );

endmodule

@@ hdl/sha1sh_checker.sv @@
// sha1sh_checker: port-level properties of the sha-1 stream hasher over time
// depends on sha1sh_pkg; bound to sha1_stream_hasher_core below
module sha1sh_checker import sha1sh_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      byte_valid,
  input logic      byte_ready,
  input in_item_t  byte_data,
  input logic      digest_valid,
  input logic      digest_ready,
  input out_item_t digest_data
);

  // a stalled digest word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    digest_valid && !digest_ready |=> digest_valid && $stable(digest_data))
    else $error("digest word changed while stalled");

  // no byte intake while digest words are pending
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    digest_valid |-> !byte_ready)
    else $error("intake open during digest output");

  // the final digest transfer ends the output burst
  a_burst_end: assert property (@(posedge clk) disable iff (rst)
    digest_valid && digest_ready && digest_data.digest_last |=> !digest_valid && byte_ready)
    else $error("output continued after last digest word");

  // an item without byte or end leaves the block idle
  a_idle_item: assert property (@(posedge clk) disable iff (rst)
    byte_valid && byte_ready && !byte_data.has_byte && !byte_data.last_byte |=> byte_ready)
    else $error("empty item started work");

  // a reset cycle leaves the block ready for bytes
  a_reset_idle: assert property (@(posedge clk)
    rst |=> byte_ready && !digest_valid)
    else $error("not idle after reset");

endmodule

bind sha1_stream_hasher_core sha1sh_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .byte_valid   (byte_valid),
  .byte_ready   (byte_ready),
  .byte_data    (byte_data),
  .digest_valid (digest_valid),
  .digest_ready (digest_ready),
  .digest_data  (digest_data)
);
